// ===== rtl/bplc_pkg.sv =====
// ----------------------------------------------------------------------------
// bplc_pkg: shared definitions for the button panel LED controller
// Widths, mode codes, register indexes, reset values and the fixed button map.
// ----------------------------------------------------------------------------
package bplc_pkg;

    // Panel geometry.
    localparam int NUM_BTN    = 10;
    localparam int NUM_DB_BTN = 9;     // buttons 0..8 go through the debouncer
    localparam int RST_BTN    = 9;     // reset button, acted on at its raw level
    localparam int NUM_ZONE   = 5;

    // Field and counter widths.
    localparam int DEB_W      = 12;
    localparam int TMR_W      = 16;
    localparam int MODE_W     = 3;
    localparam int ZSEL_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;
    localparam int MODES_W    = NUM_ZONE * MODE_W;

    // Fixed timing of the flash and of the countdown blink.
    localparam int FLASH_HALF_PERIOD     = 150;
    localparam int COUNTDOWN_HALF_PERIOD = 250;
    localparam int FREE_MOD              = 2 * FLASH_HALF_PERIOD;
    localparam int FREE_W                = $clog2(FREE_MOD);
    localparam int CD_W                  = $clog2(COUNTDOWN_HALF_PERIOD);

    localparam logic [DEB_W-1:0] STABLE_MAX = '1;
    localparam logic [TMR_W-1:0] TMR_MAX    = '1;

    // Zone mode codes.
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_OFF     = 3'd0;
    localparam t_mode MODE_GREEN   = 3'd1;
    localparam t_mode MODE_RED     = 3'd2;
    localparam t_mode MODE_FLASH_G = 3'd3;
    localparam t_mode MODE_FLASH_R = 3'd4;

    // Zone select code that addresses every zone.
    localparam logic [ZSEL_W-1:0] ZSEL_ALL = 3'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_BLINK    = 3'd1,
        CFG_HOLD     = 3'd2,
        CFG_STAGE    = 3'd3,
        CFG_FLASH    = 3'd4
    } t_cfg_idx;

    // Register reset values.
    localparam logic [DEB_W-1:0] DEB_RST   = 12'd120;
    localparam logic [TMR_W-1:0] BLINK_RST = 16'd300;
    localparam logic [TMR_W-1:0] HOLD_RST  = 16'd5000;
    localparam logic [TMR_W-1:0] STAGE_RST = 16'd1000;
    localparam logic [TMR_W-1:0] FLASH_RST = 16'd900;

    // Fixed press map: zones each debounced button touches and the mode it sets.
    typedef logic [NUM_ZONE-1:0] t_zmask;
    localparam t_zmask BTN_ZONES [NUM_DB_BTN] = '{
        5'b11111, 5'b00001, 5'b00001, 5'b00010, 5'b00010,
        5'b00010, 5'b00010, 5'b00010, 5'b10000
    };
    localparam t_mode BTN_MODE [NUM_DB_BTN] = '{
        MODE_FLASH_R, MODE_FLASH_G, MODE_GREEN, MODE_FLASH_G, MODE_FLASH_G,
        MODE_FLASH_R, MODE_FLASH_G, MODE_FLASH_G, MODE_FLASH_G
    };

    // Drive bits of one zone for a mode and blink phase, as {red, green}.
    function automatic logic [1:0] zone_drive(t_mode m, logic phase);
        logic [1:0] d;
        case (m)
            MODE_GREEN:   d = 2'b01;
            MODE_RED:     d = 2'b10;
            MODE_FLASH_G: d = {1'b0, phase};
            MODE_FLASH_R: d = {phase, 1'b0};
            default:      d = 2'b00;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/button_panel_led_controller.sv =====
// A word is captured in the input register and its result is then written to
// the output register. One word per cycle while the output is not stalled;
// the whole tick update is one combinational pass.
// Reset (i_rst_n low, synchronous) restores the register defaults, all zones in
// flash red, LEDs dark, all buttons released and both pipeline registers empty.
// ----------------------------------------------------------------------------
// button_panel_led_controller
// Debounces panel buttons, maps presses and LED commands to zone modes, runs the
// reset-hold countdown and all-red flash, and drives the green and red LED bits.
// ----------------------------------------------------------------------------
module button_panel_led_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [bplc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bplc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: button_levels[9:0], zone_select[12:10], mode_code[15:13]
    input  logic [bplc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: op (0 tick, 1 LED command)
    input  logic                                s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: press_events[9:0], status_event[10], green_drive[15:11],
    //        red_drive[20:16], zone_modes[35:21], zeros[39:36]
    output logic [bplc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // Configuration registers.
    logic [bplc_pkg::DEB_W-1:0] r_debounce_ticks;
    logic [bplc_pkg::TMR_W-1:0] r_blink_half_period;
    logic [bplc_pkg::TMR_W-1:0] r_reset_hold_ticks;
    logic [bplc_pkg::TMR_W-1:0] r_reset_stage_ticks;
    logic [bplc_pkg::TMR_W-1:0] r_flash_all_ticks;

    // Input register.
    logic                          r_in_valid;
    logic                          r_in_op;
    logic [bplc_pkg::NUM_BTN-1:0]  r_in_levels;
    logic [bplc_pkg::ZSEL_W-1:0]   r_in_zsel;
    bplc_pkg::t_mode               r_in_mode;

    // Result register.
    logic                          r_out_valid;
    logic [bplc_pkg::NUM_BTN-1:0]  r_out_events;
    logic                          r_out_status;
    logic [bplc_pkg::NUM_ZONE-1:0] r_out_green;
    logic [bplc_pkg::NUM_ZONE-1:0] r_out_red;
    logic [bplc_pkg::MODES_W-1:0]  r_out_modes;

    // Panel state and its next values.
    logic [bplc_pkg::NUM_DB_BTN-1:0] r_last_level,    n_last_level;
    logic [bplc_pkg::DEB_W-1:0]      r_stable_count [bplc_pkg::NUM_DB_BTN];
    logic [bplc_pkg::DEB_W-1:0]      n_stable_count [bplc_pkg::NUM_DB_BTN];
    logic [bplc_pkg::NUM_DB_BTN-1:0] r_press_latched, n_press_latched;
    bplc_pkg::t_mode                 r_zone_mode [bplc_pkg::NUM_ZONE];
    bplc_pkg::t_mode                 n_zone_mode [bplc_pkg::NUM_ZONE];
    logic                            r_blink_phase,   n_blink_phase;
    logic [bplc_pkg::TMR_W-1:0]      r_blink_count,   n_blink_count;
    logic                            r_hold_active,   n_hold_active;
    logic                            r_hold_fired,    n_hold_fired;
    logic [bplc_pkg::TMR_W-1:0]      r_hold_count,    n_hold_count;
    logic [bplc_pkg::CD_W-1:0]       r_cd_sub,        n_cd_sub;
    logic                            r_cd_par,        n_cd_par;
    logic                            r_flash_active,  n_flash_active;
    logic [bplc_pkg::TMR_W-1:0]      r_flash_count,   n_flash_count;
    logic [bplc_pkg::FREE_W-1:0]     r_free_tick,     n_free_tick;
    logic [bplc_pkg::NUM_ZONE-1:0]   r_green,         n_green;
    logic [bplc_pkg::NUM_ZONE-1:0]   r_red,           n_red;

    // Combinational results of one pass.
    logic                            advance;
    logic [bplc_pkg::NUM_BTN-1:0]    c_events;
    logic                            c_status;
    logic [bplc_pkg::MODES_W-1:0]    c_modes;
    logic [bplc_pkg::TMR_W-1:0]      c_div;
    logic [bplc_pkg::TMR_W+1:0]      c_thr1, c_thr2, c_thr3, c_thr4, c_held;
    logic [4:1]                      c_ge;
    logic [bplc_pkg::NUM_ZONE-1:0]   c_cd_zone;

    // Handshake: the input register moves on when the result register frees up.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks    <= bplc_pkg::DEB_RST;
            r_blink_half_period <= bplc_pkg::BLINK_RST;
            r_reset_hold_ticks  <= bplc_pkg::HOLD_RST;
            r_reset_stage_ticks <= bplc_pkg::STAGE_RST;
            r_flash_all_ticks   <= bplc_pkg::FLASH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bplc_pkg::CFG_DEBOUNCE: r_debounce_ticks <= i_cfg_wdata[bplc_pkg::DEB_W-1:0];
                bplc_pkg::CFG_BLINK:    r_blink_half_period <= i_cfg_wdata;
                bplc_pkg::CFG_HOLD:     r_reset_hold_ticks  <= i_cfg_wdata;
                bplc_pkg::CFG_STAGE:    r_reset_stage_ticks <= i_cfg_wdata;
                bplc_pkg::CFG_FLASH:    r_flash_all_ticks   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op     <= s_axis_tuser;
            r_in_levels <= s_axis_tdata[9:0];
            r_in_zsel   <= s_axis_tdata[12:10];
            r_in_mode   <= s_axis_tdata[15:13];
        end
    end

    // Countdown stage thresholds: stage k is reached once held >= k * stage length.
    assign c_div  = (r_reset_stage_ticks == '0) ? bplc_pkg::TMR_W'(1) : r_reset_stage_ticks;
    assign c_thr1 = {2'b00, c_div};
    assign c_thr2 = {1'b0, c_div, 1'b0};
    assign c_thr3 = c_thr1 + c_thr2;
    assign c_thr4 = {c_div, 2'b00};
    assign c_held = {2'b00, n_hold_count};
    assign c_ge[1] = c_held >= c_thr1;
    assign c_ge[2] = c_held >= c_thr2;
    assign c_ge[3] = c_held >= c_thr3;
    assign c_ge[4] = c_held >= c_thr4;
    assign c_cd_zone = {c_ge[4], c_ge[3] & ~c_ge[4], c_ge[2] & ~c_ge[3],
                        c_ge[1] & ~c_ge[2], ~c_ge[1]};

    // Next state for one word: a tick or an LED command.
    always_comb begin
        logic            lv;
        logic            settled;
        logic            flashing;
        logic            on;
        logic [1:0]      drv;
        bplc_pkg::t_mode cmd_mode;
        bplc_pkg::t_zmask touched;

        n_last_level    = r_last_level;
        n_stable_count  = r_stable_count;
        n_press_latched = r_press_latched;
        n_zone_mode     = r_zone_mode;
        n_blink_phase   = r_blink_phase;
        n_blink_count   = r_blink_count;
        n_hold_active   = r_hold_active;
        n_hold_fired    = r_hold_fired;
        n_hold_count    = r_hold_count;
        n_cd_sub        = r_cd_sub;
        n_cd_par        = r_cd_par;
        n_flash_active  = r_flash_active;
        n_flash_count   = r_flash_count;
        n_free_tick     = r_free_tick;
        n_green         = r_green;
        n_red           = r_red;
        c_events        = '0;
        c_status        = 1'b0;
        flashing        = 1'b0;
        lv              = 1'b1;
        settled         = 1'b0;
        on              = 1'b0;
        drv             = 2'b00;
        touched         = '0;
        cmd_mode        = (r_in_mode > bplc_pkg::MODE_FLASH_R) ? bplc_pkg::MODE_OFF : r_in_mode;

        if (!r_in_op) begin
            // Free-running timers.
            n_free_tick = (r_free_tick == bplc_pkg::FREE_W'(bplc_pkg::FREE_MOD - 1)) ?
                          '0 : r_free_tick + 1'b1;
            if (r_blink_count != bplc_pkg::TMR_MAX) begin
                n_blink_count = r_blink_count + 1'b1;
            end
            if (r_flash_active && r_flash_count != bplc_pkg::TMR_MAX) begin
                n_flash_count = r_flash_count + 1'b1;
            end
            // Hold counter with its countdown blink phase kept alongside.
            if (r_hold_active && r_hold_count != bplc_pkg::TMR_MAX) begin
                n_hold_count = r_hold_count + 1'b1;
                if (r_cd_sub == bplc_pkg::CD_W'(bplc_pkg::COUNTDOWN_HALF_PERIOD - 1)) begin
                    n_cd_sub = '0;
                    n_cd_par = ~r_cd_par;
                end else begin
                    n_cd_sub = r_cd_sub + 1'b1;
                end
            end

            // Debounce and press detection, each button on its own.
            for (int b = 0; b < bplc_pkg::NUM_DB_BTN; b++) begin
                lv = r_in_levels[b];
                if (lv != r_last_level[b]) begin
                    n_last_level[b]   = lv;
                    n_stable_count[b] = '0;
                end else if (r_stable_count[b] != bplc_pkg::STABLE_MAX) begin
                    n_stable_count[b] = r_stable_count[b] + 1'b1;
                end
                settled = n_stable_count[b] >= r_debounce_ticks;
                if (!lv && !r_press_latched[b] && settled) begin
                    n_press_latched[b] = 1'b1;
                    c_events[b]        = 1'b1;
                end
                if (lv && r_press_latched[b] && settled) begin
                    n_press_latched[b] = 1'b0;
                end
            end

            // Press map, later buttons overriding earlier ones.
            for (int b = 0; b < bplc_pkg::NUM_DB_BTN; b++) begin
                if (c_events[b]) begin
                    touched = touched | bplc_pkg::BTN_ZONES[b];
                    for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                        if (bplc_pkg::BTN_ZONES[b][z]) begin
                            n_zone_mode[z] = bplc_pkg::BTN_MODE[b];
                        end
                    end
                end
            end
            for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                if (touched[z]) begin
                    drv        = bplc_pkg::zone_drive(n_zone_mode[z], r_blink_phase);
                    n_green[z] = drv[0];
                    n_red[z]   = drv[1];
                end
            end

            // Reset button: hold, fire and countdown display.
            if (!r_in_levels[bplc_pkg::RST_BTN]) begin
                if (!r_hold_active) begin
                    n_hold_active = 1'b1;
                    n_hold_fired  = 1'b0;
                    n_hold_count  = '0;
                    n_cd_sub      = '0;
                    n_cd_par      = 1'b0;
                end
                if (!n_hold_fired && n_hold_count >= r_reset_hold_ticks) begin
                    n_hold_fired                = 1'b1;
                    c_events[bplc_pkg::RST_BTN] = 1'b1;
                    n_flash_active              = 1'b1;
                    n_flash_count               = '0;
                end
                if (!n_hold_fired) begin
                    n_green = '0;
                    n_red   = c_cd_zone & {bplc_pkg::NUM_ZONE{~n_cd_par}};
                end
            end else if (r_hold_active) begin
                n_hold_active = 1'b0;
                n_hold_fired  = 1'b0;
                n_hold_count  = '0;
                if (!r_flash_active) begin
                    for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                        drv        = bplc_pkg::zone_drive(n_zone_mode[z], r_blink_phase);
                        n_green[z] = drv[0];
                        n_red[z]   = drv[1];
                    end
                end
            end

            // All-red flash, ending in flash red everywhere and a status event.
            if (n_flash_active) begin
                if (n_flash_count >= r_flash_all_ticks) begin
                    n_flash_active = 1'b0;
                    n_flash_count  = '0;
                    c_status       = 1'b1;
                    for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                        n_zone_mode[z] = bplc_pkg::MODE_FLASH_R;
                    end
                    n_green = '0;
                    n_red   = {bplc_pkg::NUM_ZONE{r_blink_phase}};
                end else begin
                    on       = n_free_tick < bplc_pkg::FREE_W'(bplc_pkg::FLASH_HALF_PERIOD);
                    n_green  = '0;
                    n_red    = {bplc_pkg::NUM_ZONE{on}};
                    flashing = 1'b1;
                end
            end

            // Shared blink phase toggle.
            if (!flashing && !n_hold_active && n_blink_count >= r_blink_half_period) begin
                n_blink_count = '0;
                n_blink_phase = ~r_blink_phase;
                for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                    drv        = bplc_pkg::zone_drive(n_zone_mode[z], n_blink_phase);
                    n_green[z] = drv[0];
                    n_red[z]   = drv[1];
                end
            end
        end else begin
            // LED command: one zone or all; unknown selects are ignored.
            for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                if (r_in_zsel == bplc_pkg::ZSEL_W'(z) || r_in_zsel == bplc_pkg::ZSEL_ALL) begin
                    n_zone_mode[z] = cmd_mode;
                    drv            = bplc_pkg::zone_drive(cmd_mode, r_blink_phase);
                    n_green[z]     = drv[0];
                    n_red[z]       = drv[1];
                end
            end
        end
    end

    // Pack the zone modes, zone 0 lowest.
    always_comb begin
        for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
            c_modes[z*bplc_pkg::MODE_W +: bplc_pkg::MODE_W] = n_zone_mode[z];
        end
    end

    // Panel state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level    <= '1;
            r_press_latched <= '0;
            for (int b = 0; b < bplc_pkg::NUM_DB_BTN; b++) begin
                r_stable_count[b] <= '0;
            end
            for (int z = 0; z < bplc_pkg::NUM_ZONE; z++) begin
                r_zone_mode[z] <= bplc_pkg::MODE_FLASH_R;
            end
            r_blink_phase  <= 1'b0;
            r_blink_count  <= '0;
            r_hold_active  <= 1'b0;
            r_hold_fired   <= 1'b0;
            r_hold_count   <= '0;
            r_cd_sub       <= '0;
            r_cd_par       <= 1'b0;
            r_flash_active <= 1'b0;
            r_flash_count  <= '0;
            r_free_tick    <= '0;
            r_green        <= '0;
            r_red          <= '0;
        end else if (advance) begin
            r_last_level    <= n_last_level;
            r_press_latched <= n_press_latched;
            r_stable_count  <= n_stable_count;
            r_zone_mode     <= n_zone_mode;
            r_blink_phase   <= n_blink_phase;
            r_blink_count   <= n_blink_count;
            r_hold_active   <= n_hold_active;
            r_hold_fired    <= n_hold_fired;
            r_hold_count    <= n_hold_count;
            r_cd_sub        <= n_cd_sub;
            r_cd_par        <= n_cd_par;
            r_flash_active  <= n_flash_active;
            r_flash_count   <= n_flash_count;
            r_free_tick     <= n_free_tick;
            r_green         <= n_green;
            r_red           <= n_red;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_events <= c_events;
            r_out_status <= c_status;
            r_out_green  <= n_green;
            r_out_red    <= n_red;
            r_out_modes  <= c_modes;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_modes, r_out_red, r_out_green,
                            r_out_status, r_out_events};

    // A fired hold only exists while the hold is active.
    a_fired_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_fired |-> r_hold_active)
        else $error("hold fired without an active hold");

    // Idle hold and flash timers rest at zero.
    a_hold_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hold_active |-> (r_hold_count == '0))
        else $error("hold counter running while no hold is active");

    a_flash_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_flash_active |-> (r_flash_count == '0))
        else $error("flash counter running while no flash is active");

    // A command word never reports a press or a status event.
    a_cmd_no_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op) |=> (r_out_events == '0 && !r_out_status))
        else $error("command word produced an event");

    // A status event always leaves every zone in flash red.
    a_status_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |->
        (r_out_modes == {bplc_pkg::NUM_ZONE{bplc_pkg::MODE_FLASH_R}}))
        else $error("status event without all zones in flash red");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the button panel LED controller
// Streams millisecond ticks and LED commands into the block, predicts every
// result word with an internal copy of the panel state, and compares each
// output word field by field. Runs directed checks, several register settings
// with random button traffic, and one long hold that drives the saturating timers
// into saturation.
// ----------------------------------------------------------------------------
module tb;

    import bplc_pkg::*;

    // Operation codes carried in tuser.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_LED_CMD = 1'b1;

    localparam int RESET_BTN         = 9;
    localparam int ZONES             = 5;
    localparam int FLASH_HALF_MS     = 150;
    localparam int COUNTDOWN_HALF_MS = 250;
    localparam int STALL_LIMIT       = 2000;

    // One expected result word.
    typedef struct packed {
        logic [9:0]  presses;
        logic        status;
        logic [4:0]  green;
        logic [4:0]  red;
        logic [14:0] modes;
    } t_panel_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // button_levels[9:0], zone_select[12:10], mode_code[15:13]
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // press_events[9:0], status_event[10], green[15:11],
                                 // red[20:16], zone_modes[35:21], zeros[39:36]

    button_panel_led_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_panel_out pending_panel[$];
    int         mismatches;
    int         result_no;
    logic       calm;       // no idling on either side while set

    // Panel state mirrored by the predictor.
    logic [11:0] deb_ticks;
    logic [15:0] blink_len, hold_len, stage_len, flash_len;
    logic [9:0]  lvl_last;
    logic [11:0] stable_cnt [10];
    logic [9:0]  latched;
    t_mode       zmode [ZONES];
    logic        blink_ph;
    logic [15:0] blink_cnt;
    logic        hold_on, hold_done;
    logic [15:0] hold_cnt;
    logic        flash_on;
    logic [15:0] flash_cnt;
    int          free_ms;
    logic [4:0]  green_now, red_now;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] sat_up16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [11:0] sat_up12(logic [11:0] v);
        return (v == 12'hFFF) ? v : v + 12'd1;
    endfunction

    function automatic void clear_panel_state();
        deb_ticks = 12'd120;
        blink_len = 16'd300;
        hold_len  = 16'd5000;
        stage_len = 16'd1000;
        flash_len = 16'd900;
        lvl_last  = '1;
        latched   = '0;
        for (int b = 0; b < 10; b++) stable_cnt[b] = '0;
        for (int z = 0; z < ZONES; z++) zmode[z] = MODE_FLASH_R;
        blink_ph  = 1'b0;
        blink_cnt = '0;
        hold_on   = 1'b0;
        hold_done = 1'b0;
        hold_cnt  = '0;
        flash_on  = 1'b0;
        flash_cnt = '0;
        free_ms   = 0;
        green_now = '0;
        red_now   = '0;
    endfunction

    // Drive bits of one zone from its mode and the shared blink phase.
    function automatic void paint_zone(int z);
        green_now[z] = (zmode[z] == MODE_GREEN) || (zmode[z] == MODE_FLASH_G && blink_ph);
        red_now[z]   = (zmode[z] == MODE_RED) || (zmode[z] == MODE_FLASH_R && blink_ph);
    endfunction

    function automatic void repaint_all();
        for (int z = 0; z < ZONES; z++) paint_zone(z);
    endfunction

    function automatic void set_zone_mode(int z, t_mode m);
        zmode[z] = m;
        paint_zone(z);
    endfunction

    function automatic void set_every_zone(t_mode m);
        for (int z = 0; z < ZONES; z++) zmode[z] = m;
        repaint_all();
    endfunction

    // Fixed map from a debounced press to the zone mode it sets.
    function automatic void apply_press(int b);
        case (b)
            0:          set_every_zone(MODE_FLASH_R);
            1:          set_zone_mode(0, MODE_FLASH_G);
            2:          set_zone_mode(0, MODE_GREEN);
            5:          set_zone_mode(1, MODE_FLASH_R);
            3, 4, 6, 7: set_zone_mode(1, MODE_FLASH_G);
            8:          set_zone_mode(4, MODE_FLASH_G);
            default:    ;
        endcase
    endfunction

    // Countdown during a reset hold: one blinking red LED per stage.
    function automatic void show_hold_stage(logic [15:0] held);
        int   div;
        int   stage;
        logic lit;
        div   = (stage_len == 16'd0) ? 1 : int'(stage_len);
        stage = int'(held) / div;
        if (stage > 4) stage = 4;
        lit   = ((int'(held) / COUNTDOWN_HALF_MS) % 2) == 0;
        for (int z = 0; z < ZONES; z++) begin
            green_now[z] = 1'b0;
            red_now[z]   = (z == stage) && lit;
        end
    endfunction

    // One millisecond of panel time.
    function automatic void run_tick(input logic [9:0] lv, output logic [9:0] ev,
                                     output logic st);
        logic settled;
        logic flashing;
        logic lit;
        ev = '0;
        st = 1'b0;
        free_ms   = (free_ms + 1) % (2 * FLASH_HALF_MS);
        blink_cnt = sat_up16(blink_cnt);
        if (flash_on) flash_cnt = sat_up16(flash_cnt);
        if (hold_on) hold_cnt = sat_up16(hold_cnt);

        for (int b = 0; b < 10; b++) begin
            if (lv[b] != lvl_last[b]) begin
                lvl_last[b]   = lv[b];
                stable_cnt[b] = '0;
            end else begin
                stable_cnt[b] = sat_up12(stable_cnt[b]);
            end
            settled = stable_cnt[b] >= deb_ticks;

            if (b == RESET_BTN && !lv[b]) begin
                // The reset button acts on its raw level.
                if (!hold_on) begin
                    hold_on   = 1'b1;
                    hold_done = 1'b0;
                    hold_cnt  = '0;
                end
                if (!hold_done && hold_cnt >= hold_len) begin
                    hold_done  = 1'b1;
                    latched[b] = 1'b1;
                    ev[b]      = 1'b1;
                    flash_on   = 1'b1;
                    flash_cnt  = '0;
                end
                if (!hold_done) show_hold_stage(hold_cnt);
            end else begin
                if (b == RESET_BTN) begin
                    if (hold_on) begin
                        hold_on   = 1'b0;
                        hold_done = 1'b0;
                        hold_cnt  = '0;
                        if (!flash_on) repaint_all();
                    end
                end else if (!lv[b] && !latched[b] && settled) begin
                    latched[b] = 1'b1;
                    ev[b]      = 1'b1;
                    apply_press(b);
                end
                if (lv[b] && latched[b] && settled) latched[b] = 1'b0;
            end
        end

        // All-red flash after a completed hold, then the status event.
        flashing = 1'b0;
        if (flash_on) begin
            if (flash_cnt >= flash_len) begin
                flash_on  = 1'b0;
                flash_cnt = '0;
                set_every_zone(MODE_FLASH_R);
                st = 1'b1;
            end else begin
                lit       = free_ms < FLASH_HALF_MS;
                green_now = '0;
                red_now   = {5{lit}};
                flashing  = 1'b1;
            end
        end
        if (!flashing && !hold_on && blink_cnt >= blink_len) begin
            blink_cnt = '0;
            blink_ph  = ~blink_ph;
            repaint_all();
        end
    endfunction

    function automatic t_panel_out predict_panel(logic op, logic [15:0] word);
        t_panel_out res;
        logic [9:0] ev;
        logic       st;
        t_mode      m;
        int         sel;
        ev  = '0;
        st  = 1'b0;
        if (op == OP_TICK) begin
            run_tick(word[9:0], ev, st);
        end else begin
            sel = int'(word[12:10]);
            m   = (word[15:13] > MODE_FLASH_R) ? MODE_OFF : t_mode'(word[15:13]);
            if (sel < ZONES) set_zone_mode(sel, m);
            else if (word[12:10] == ZSEL_ALL) set_every_zone(m);
        end
        res.presses = ev;
        res.status  = st;
        res.green   = green_now;
        res.red     = red_now;
        res.modes   = {zmode[4], zmode[3], zmode[2], zmode[1], zmode[0]};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [15:0] word);
        if (!calm) begin
            while ($urandom_range(99) < 20) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_panel.push_back(predict_panel(op, word));
    endtask

    // Tick word; the command fields carry random filler.
    task automatic send_tick(input logic [9:0] lv);
        logic [2:0] fill_a, fill_b;
        fill_a = $urandom_range(0, 7);
        fill_b = $urandom_range(0, 7);
        send_word(OP_TICK, {fill_a, fill_b, lv});
    endtask

    // LED command word; the level field carries random filler.
    task automatic send_command(input logic [2:0] zsel, input logic [2:0] mode);
        logic [9:0] fill;
        fill = $urandom_range(0, 1023);
        send_word(OP_LED_CMD, {mode, zsel, fill});
    endtask

    // Hold the input back until every expected word has come out.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_panel.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: deb_ticks = val[11:0];
            CFG_BLINK:    blink_len = val;
            CFG_HOLD:     hold_len  = val;
            CFG_STAGE:    stage_len = val;
            CFG_FLASH:    flash_len = val;
            default:      ;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] deb, input logic [15:0] blink,
                              input logic [15:0] hold, input logic [15:0] stage,
                              input logic [15:0] flash);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_BLINK, blink);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_STAGE, stage);
        write_reg(CFG_FLASH, flash);
    endtask

    task automatic hold_levels(input logic [9:0] lv, input int count);
        for (int i = 0; i < count; i++) send_tick(lv);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("word %0d: %s mismatch, got %0h, expected %0h", result_no, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_panel_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_panel.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, '0);
            end else begin
                want = pending_panel.pop_front();
                if (m_axis_tdata[9:0] !== want.presses)
                    report_mismatch("press_events", m_axis_tdata[9:0], want.presses);
                if (m_axis_tdata[10] !== want.status)
                    report_mismatch("status_event", m_axis_tdata[10], want.status);
                if (m_axis_tdata[15:11] !== want.green)
                    report_mismatch("green_drive", m_axis_tdata[15:11], want.green);
                if (m_axis_tdata[20:16] !== want.red)
                    report_mismatch("red_drive", m_axis_tdata[20:16], want.red);
                if (m_axis_tdata[35:21] !== want.modes)
                    report_mismatch("zone_modes", m_axis_tdata[35:21], want.modes);
                if (m_axis_tdata[39:36] !== 4'd0)
                    report_mismatch("padding", m_axis_tdata[39:36], '0);
            end
            result_no++;
        end
    end

    // Output back-pressure: ready drops with a probability of about one in five unless calm.
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 20);
    end

    // Watchdog on cycles in which neither side moves a word.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d idle cycles", STALL_LIMIT);
        $display("[button_panel_led_controller] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every zone select and mode code, then all-high, all-low and alternating button levels.
    task automatic test_commands();
        for (int v = 0; v < 8; v++) send_command(v[2:0], v[2:0]);
        send_command(ZSEL_ALL, 3'd7);
        send_command(ZSEL_ALL, MODE_FLASH_R);
        send_command(3'd2, MODE_RED);
        send_tick(10'h3FF);
        send_tick(10'h000);
        send_tick(10'h000);
        send_tick(10'h3FF);
        send_tick(10'h2AA);
        send_tick(10'h155);
        send_tick(10'h3FF);
    endtask

    // Zero debounce, blink, stage and flash registers, then a zero hold register.
    task automatic test_zero_timing();
        set_timing(16'd0, 16'd0, 16'd10, 16'd0, 16'd0);
        hold_levels(10'h1FF, 14);
        hold_levels(10'h3FF, 3);
        hold_levels(10'h3FD, 3);
        hold_levels(10'h3FB, 3);
        hold_levels(10'h3FF, 2);
        write_reg(CFG_HOLD, 16'd0);
        hold_levels(10'h1FF, 4);
        hold_levels(10'h3FF, 3);
    endtask

    // A second completed hold while the flash runs restarts the flash.
    task automatic test_hold_restart();
        set_timing(16'd2, 16'd5, 16'd6, 16'd2, 16'd40);
        hold_levels(10'h1FF, 9);
        hold_levels(10'h3FF, 3);
        hold_levels(10'h1FF, 9);
        hold_levels(10'h3FF, 50);
    endtask

    // Random button traffic: mostly press-and-hold runs, some noise and commands.
    task automatic play_random_items(input int count, input logic drain_midway);
        int         done;
        int         kind;
        int         span;
        int         len;
        logic       drained;
        logic [9:0] base_lv;
        logic [9:0] lv;
        done    = 0;
        drained = 1'b0;
        while (done < count) begin
            if (drain_midway && !drained && done >= count / 2) begin
                wait_drain();
                drained = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 10) begin
                send_command($urandom_range(0, 7), $urandom_range(0, 7));
                done++;
            end else if (kind < 18) begin
                send_tick($urandom_range(0, 1023));
                done++;
            end else begin
                base_lv = 10'h3FF;
                if ($urandom_range(99) < 35) base_lv[RESET_BTN] = 1'b0;
                repeat ($urandom_range(0, 2)) base_lv[$urandom_range(0, 8)] = 1'b0;
                if ($urandom_range(1))
                    span = int'(deb_ticks) + 4;
                else
                    span = int'(deb_ticks) + int'(hold_len) + int'(flash_len) + 4;
                len = $urandom_range(1, span);
                for (int i = 0; i < len; i++) begin
                    lv = base_lv;
                    if ($urandom_range(99) < 4) lv[$urandom_range(0, 9)] ^= 1'b1;
                    send_tick(lv);
                    done++;
                end
                len = $urandom_range(1, int'(deb_ticks) + 4);
                for (int i = 0; i < len; i++) begin
                    lv = 10'h3FF;
                    if ($urandom_range(99) < 4) lv[$urandom_range(0, 9)] ^= 1'b1;
                    send_tick(lv);
                    done++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        // Smallest settings, with no idling on either side.
        calm = 1'b1;
        set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        play_random_items(200, 1'b0);
        calm = 1'b0;
        for (int p = 0; p < 3; p++) begin
            set_timing($urandom_range(1, 6), $urandom_range(1, 40), $urandom_range(1, 80),
                       $urandom_range(0, 20), $urandom_range(1, 60));
            play_random_items(200, 1'b0);
        end
        // Long enough holds for the countdown and flash half periods to show.
        set_timing($urandom_range(1, 6), $urandom_range(20, 400), $urandom_range(250, 600),
                   $urandom_range(40, 150), $urandom_range(100, 300));
        play_random_items(400, 1'b0);
        set_timing($urandom_range(1, 6), $urandom_range(1, 40), $urandom_range(1, 80),
                   $urandom_range(0, 20), $urandom_range(1, 60));
        play_random_items(200, 1'b1);
    endtask

    // Largest settings but the stage length: timers saturate during one very long hold.
    task automatic test_long_hold();
        calm = 1'b1;
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3000, 16'hFFFF);
        hold_levels(10'h1FE, 4200);
        hold_levels(10'h1FF, 127000);
        hold_levels(10'h3FF, 20);
        write_reg(CFG_STAGE, 16'hFFFF);
        hold_levels(10'h1FF, 10);
        hold_levels(10'h3FF, 5);
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_DEBOUNCE;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_TICK;
        m_axis_tready <= 1'b0;
        calm          = 1'b0;
        mismatches    = 0;
        result_no     = 0;
        clear_panel_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_zero_timing();
        test_hold_restart();
        test_random_traffic();
        test_long_hold();

        wait_drain();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && pending_panel.size() == 0) begin
            $display("[button_panel_led_controller] OK");
        end else begin
            $display("[button_panel_led_controller] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bplc_pkg.sv
rtl/button_panel_led_controller.sv
bench/tb.sv
